[hdl/ccs_pkg.sv]
// ----------------------------------------------------------------------------
// ccs_pkg: shared types and constants for the calendar countdown
// Beat payloads, register indexes, time constants and the month length table.
// ----------------------------------------------------------------------------
package ccs_pkg;

  typedef struct packed {
    logic [11:0] now_year;
    logic [3:0]  now_month;
    logic [4:0]  now_day;
    logic [4:0]  now_hour;
    logic [5:0]  now_minute;
    logic [5:0]  now_second;
  } tick_t;

  typedef struct packed {
    logic [31:0] seconds_left;
    logic        final_window;
  } result_t;

  typedef enum logic [2:0] {
    REG_MODE_FROM_NOW       = 3'd0,
    REG_TARGET_YEAR         = 3'd1,
    REG_TARGET_MONTH        = 3'd2,
    REG_TARGET_DAY          = 3'd3,
    REG_TARGET_HOUR         = 3'd4,
    REG_TARGET_MINUTE       = 3'd5,
    REG_DELAY_MINUTES       = 3'd6,
    REG_DELAY_EXTRA_SECONDS = 3'd7
  } cfg_reg_t;

  localparam int CFG_DATA_W = 16;

  localparam logic [16:0] SECS_PER_DAY      = 17'd86400;
  localparam logic [16:0] SECS_PER_HOUR     = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN      = 17'd60;
  localparam logic [17:0] DAYS_PER_CYCLE    = 18'd146097;  // days in 400 years
  localparam logic [11:0] YEARS_PER_CYCLE   = 12'd400;
  localparam logic [12:0] YEARS_PER_CENTURY = 13'd100;
  localparam logic [6:0]  LAST_YEAR_OF_CENT = 7'd99;
  localparam logic [31:0] FINAL_WINDOW_SECS = 32'd30;
  localparam logic [3:0]  FEBRUARY          = 4'd1;

  // codes above december count as 31-day months
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    begin
      case (m)
        4'd1:                        d = leap ? 5'd29 : 5'd28;
        4'd3, 4'd5, 4'd8, 4'd10:     d = 5'd30;
        default:                     d = 5'd31;
      endcase
      return d;
    end
  endfunction

endpackage

[hdl/calendar_countdown_seconds.sv]
// ----------------------------------------------------------------------------
// calendar_countdown_seconds: seconds left until a calendar date or a delay
// Per tick beat, returns the clamped and saturated countdown in seconds.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel writes one of eight registers (cfg_index, cfg_data); it is
//   always ready and should only be used while no tick is in flight.
//   in channel takes one tick beat with the current calendar time; out
//   channel returns one result beat per tick.
//   Sequence: from-now mode goes from accept to the minute multiply and
//   then the final step. Date mode first finds leap data by repeated
//   subtraction of 100 in two passes, then walks years (400-year blocks,
//   then one year per cycle, at most 408 steps) and months (at most 15
//   steps) on a single day adder, then the day, hour and minute terms on
//   the shared multiply-accumulate unit and the clamping step.
//   Throughput: one tick at a time; in_ready is high only while the
//   sequencer is idle. A finished result sits in the output register and
//   a new tick may be accepted meanwhile; if the receiver stalls, the next
//   result waits in the final step until the register frees up.
//   Reset restores the register defaults and clears the from-now state;
//   the first tick after reset loads the minute delay.
// ----------------------------------------------------------------------------
module calendar_countdown_seconds (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [2:0]                        cfg_index,
  input  logic [ccs_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ccs_pkg::tick_t                    in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ccs_pkg::result_t                  out_data
);
  import ccs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV_T, S_DIV_W, S_YEAR, S_MONTH, S_MUL_D, S_MUL_H, S_MUL_M, S_FIN
  } state_t;

  state_t state;

  logic        mode_from_now;
  logic [11:0] target_year;
  logic [3:0]  target_month;
  logic [4:0]  target_day;
  logic [4:0]  target_hour;
  logic [5:0]  target_minute;
  logic [15:0] delay_minutes;
  logic [5:0]  delay_extra_seconds;

  logic        started;
  logic [5:0]  last_minute_seen;
  logic [15:0] remaining_minutes;

  tick_t              cur;
  logic               year_fwd, month_fwd, ty_leap;
  logic [11:0]        yr, yr_hi;
  logic [3:0]         mon, mon_hi;
  logic [12:0]        dv;
  logic [1:0]         cq;
  logic [6:0]         ly_mod100;
  logic [1:0]         ly_cent;
  logic signed [23:0] days;
  logic signed [43:0] acc;

  // combinational
  logic               in_fire, out_free;
  logic [15:0]        rem_cur, rem_next;
  logic [5:0]         last_cur, last_next;
  logic               div_ge, div_leap, walk_leap, big_step, step_fwd;
  logic [11:0]        yr_gap;
  logic [17:0]        step_days;
  logic signed [23:0] days_step;
  logic signed [23:0] mul_a;
  logic [16:0]        mul_k;
  logic signed [41:0] product;
  logic signed [43:0] acc_sum, fin_total;
  logic [5:0]         extra_sel;
  logic [31:0]        secs;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // from-now bookkeeping at tick accept
  always_comb begin
    rem_cur   = started ? remaining_minutes : delay_minutes;
    last_cur  = started ? last_minute_seen : in_data.now_minute;
    rem_next  = rem_cur;
    last_next = last_cur;
    if (mode_from_now && (in_data.now_minute != last_cur)) begin
      last_next = in_data.now_minute;
      if (rem_cur != 16'd0) begin
        rem_next = rem_cur - 16'd1;
      end
    end
  end

  // leap test: y%4 equals (y%100)%4 since 100 is a multiple of 4
  assign div_ge    = (dv >= YEARS_PER_CENTURY);
  assign div_leap  = (dv[1:0] == 2'd0) && ((dv != 13'd0) || (cq == 2'd0));
  assign walk_leap = (ly_mod100[1:0] == 2'd0) && ((ly_mod100 != 7'd0) || (ly_cent == 2'd0));
  assign yr_gap    = yr_hi - yr;
  assign big_step  = (yr_gap >= YEARS_PER_CYCLE);

  always_comb begin
    if (state == S_YEAR) begin
      step_fwd = year_fwd;
      if (big_step) begin
        step_days = DAYS_PER_CYCLE;
      end else begin
        step_days = walk_leap ? 18'd366 : 18'd365;
      end
    end else begin
      step_fwd  = month_fwd;
      step_days = {13'd0, month_days(mon, ty_leap)};
    end
    days_step = step_fwd ? days + $signed({6'd0, step_days})
                         : days - $signed({6'd0, step_days});
  end

  // shared multiply-accumulate unit
  always_comb begin
    unique case (state)
      S_MUL_D: begin
        mul_a = days;
        mul_k = SECS_PER_DAY;
      end
      S_MUL_H: begin
        mul_a = $signed({19'd0, target_hour}) - $signed({19'd0, cur.now_hour});
        mul_k = SECS_PER_HOUR;
      end
      default: begin
        if (mode_from_now) begin
          mul_a = $signed({8'd0, remaining_minutes});
        end else begin
          mul_a = $signed({18'd0, target_minute}) - $signed({18'd0, cur.now_minute});
        end
        mul_k = SECS_PER_MIN;
      end
    endcase
    product = mul_a * $signed({1'b0, mul_k});
    acc_sum = acc + {{2{product[41]}}, product};
  end

  always_comb begin
    extra_sel = mode_from_now ? delay_extra_seconds : 6'd0;
    fin_total = acc + $signed({38'd0, extra_sel}) - $signed({38'd0, cur.now_second});
    if (fin_total[43]) begin
      secs = 32'd0;
    end else if (fin_total[43:32] != 12'd0) begin
      secs = 32'hFFFF_FFFF;
    end else begin
      secs = fin_total[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      mode_from_now       <= 1'b0;
      target_year         <= 12'd2000;
      target_month        <= 4'd0;
      target_day          <= 5'd1;
      target_hour         <= 5'd0;
      target_minute       <= 6'd0;
      delay_minutes       <= 16'd0;
      delay_extra_seconds <= 6'd0;
      started             <= 1'b0;
      last_minute_seen    <= 6'd0;
      remaining_minutes   <= 16'd0;
      out_valid           <= 1'b0;
    end else begin
      // a new result beat replaces the one leaving in the same cycle
      if ((state == S_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_MODE_FROM_NOW:       mode_from_now       <= cfg_data[0];
          REG_TARGET_YEAR:         target_year         <= cfg_data[11:0];
          REG_TARGET_MONTH:        target_month        <= cfg_data[3:0];
          REG_TARGET_DAY:          target_day          <= cfg_data[4:0];
          REG_TARGET_HOUR:         target_hour         <= cfg_data[4:0];
          REG_TARGET_MINUTE:       target_minute       <= cfg_data[5:0];
          REG_DELAY_MINUTES:       delay_minutes       <= cfg_data[15:0];
          REG_DELAY_EXTRA_SECONDS: delay_extra_seconds <= cfg_data[5:0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            cur               <= in_data;
            started           <= 1'b1;
            last_minute_seen  <= last_next;
            remaining_minutes <= rem_next;
            acc               <= '0;
            year_fwd          <= (in_data.now_year < target_year);
            yr                <= (in_data.now_year < target_year) ? in_data.now_year
                                                                  : target_year;
            yr_hi             <= (in_data.now_year < target_year) ? target_year
                                                                  : in_data.now_year;
            month_fwd         <= (in_data.now_month < target_month);
            mon               <= (in_data.now_month < target_month) ? in_data.now_month
                                                                    : target_month;
            mon_hi            <= (in_data.now_month < target_month) ? target_month
                                                                    : in_data.now_month;
            days              <= $signed({19'd0, target_day}) - $signed({19'd0, in_data.now_day});
            dv                <= {1'b0, target_year};
            cq                <= 2'd0;
            state             <= mode_from_now ? S_MUL_M : S_DIV_T;
          end
        end

        // target year leap flag for the february length
        S_DIV_T: begin
          if (div_ge) begin
            dv <= dv - YEARS_PER_CENTURY;
            cq <= cq + 2'd1;
          end else begin
            ty_leap <= div_leap;
            // walk tracks the year that holds the next february
            dv      <= {1'b0, yr} + {12'd0, (target_month > FEBRUARY)};
            cq      <= 2'd0;
            state   <= S_DIV_W;
          end
        end

        S_DIV_W: begin
          if (div_ge) begin
            dv <= dv - YEARS_PER_CENTURY;
            cq <= cq + 2'd1;
          end else begin
            ly_mod100 <= dv[6:0];
            ly_cent   <= cq;
            state     <= S_YEAR;
          end
        end

        S_YEAR: begin
          if (yr == yr_hi) begin
            state <= S_MONTH;
          end else begin
            days <= days_step;
            if (big_step) begin
              // 400 years leave both counters unchanged
              yr <= yr + YEARS_PER_CYCLE;
            end else begin
              yr <= yr + 12'd1;
              if (ly_mod100 == LAST_YEAR_OF_CENT) begin
                ly_mod100 <= 7'd0;
                ly_cent   <= ly_cent + 2'd1;
              end else begin
                ly_mod100 <= ly_mod100 + 7'd1;
              end
            end
          end
        end

        S_MONTH: begin
          if (mon == mon_hi) begin
            state <= S_MUL_D;
          end else begin
            days <= days_step;
            mon  <= mon + 4'd1;
          end
        end

        S_MUL_D: begin
          acc   <= acc_sum;
          state <= S_MUL_H;
        end

        S_MUL_H: begin
          acc   <= acc_sum;
          state <= S_MUL_M;
        end

        S_MUL_M: begin
          acc   <= acc_sum;
          state <= S_FIN;
        end

        S_FIN: begin
          if (out_free) begin
            out_data.seconds_left <= secs;
            out_data.final_window <= (secs <= FINAL_WINDOW_SECS);
            state                 <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[test/calendar_countdown_seconds_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_countdown_seconds_tb: self-checking bench for the calendar countdown
// Sends clock tick beats in date and from-now modes, predicts the countdown of
// each tick in the bench, and compares every result beat field by field while
// both channels idle and stall at random.
// ----------------------------------------------------------------------------
module calendar_countdown_seconds_tb;
  import ccs_pkg::*;

  localparam int RANDOM_TICKS = 700;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  tick_t in_data;
  logic out_valid;
  logic out_ready = 1'b0;
  result_t out_data;

  // bench copy of the registers and the from-now state
  logic        cfg_mode;
  logic [11:0] tgt_year;
  logic [3:0]  tgt_month;
  logic [4:0]  tgt_day;
  logic [4:0]  tgt_hour;
  logic [5:0]  tgt_minute;
  logic [15:0] dly_minutes;
  logic [5:0]  dly_extra;
  bit          cd_started;
  logic [5:0]  cd_last_minute;
  logic [15:0] cd_remaining;

  result_t countdown_q[$];
  int errors;
  int sent_ticks;
  bit calm;
  int stall_left;

  calendar_countdown_seconds i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic bit leap_year(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // month codes above december count as 31 days
  function automatic longint month_len(int m, int y);
    if (m > 11) return 31;
    case (m)
      1:          return leap_year(y) ? 29 : 28;
      3, 5, 8, 10: return 30;
      default:    return 31;
    endcase
  endfunction

  // a year step holds the next february 29 when the target is past february
  function automatic longint year_len(int y);
    int ly;
    ly = (tgt_month > FEBRUARY) ? y + 1 : y;
    return leap_year(ly) ? 366 : 365;
  endfunction

  function automatic longint date_offset(tick_t t);
    longint days;
    int ny;
    int nm;
    int ty;
    int tm;
    ny = t.now_year;
    nm = t.now_month;
    ty = tgt_year;
    tm = tgt_month;
    days = 0;
    for (int y = ny; y < ty; y++) days += year_len(y);
    for (int y = ty; y < ny; y++) days -= year_len(y);
    for (int m = nm; m < tm; m++) days += month_len(m, ty);
    for (int m = nm; m > tm; m--) days -= month_len(m - 1, ty);
    days += longint'(tgt_day) - longint'(t.now_day);
    return days * longint'(SECS_PER_DAY)
         + (longint'(tgt_hour) - longint'(t.now_hour)) * longint'(SECS_PER_HOUR)
         + (longint'(tgt_minute) - longint'(t.now_minute)) * longint'(SECS_PER_MIN);
  endfunction

  function automatic result_t predict_countdown(tick_t t);
    longint total;
    result_t r;
    if (!cd_started) begin
      cd_started = 1'b1;
      cd_last_minute = t.now_minute;
      cd_remaining = dly_minutes;
    end
    if (cfg_mode) begin
      if (t.now_minute != cd_last_minute) begin
        cd_last_minute = t.now_minute;
        if (cd_remaining != 0) cd_remaining--;
      end
      total = longint'(cd_remaining) * longint'(SECS_PER_MIN) + longint'(dly_extra);
    end else begin
      total = date_offset(t);
    end
    total -= longint'(t.now_second);
    if (total < 0) r.seconds_left = '0;
    else if (total > longint'(32'hFFFF_FFFF)) r.seconds_left = '1;
    else r.seconds_left = total[31:0];
    r.final_window = (r.seconds_left <= FINAL_WINDOW_SECS);
    return r;
  endfunction

  function automatic tick_t make_tick(int y, int m, int d, int h, int mi, int s);
    tick_t t;
    t.now_year = y[11:0];
    t.now_month = m[3:0];
    t.now_day = d[4:0];
    t.now_hour = h[4:0];
    t.now_minute = mi[5:0];
    t.now_second = s[5:0];
    return t;
  endfunction

  function automatic tick_t noise_tick();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(tick_t)-1:0];
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (countdown_q.size() != 0) @(posedge clk);
  endtask

  // writes all eight registers once the block has gone idle
  task automatic load_settings(input logic [15:0] mode, ty, tm, td, th, tmi, dly, extra);
    logic [15:0] vals [8];
    cfg_reg_t idx;
    vals[0] = mode;
    vals[1] = ty;
    vals[2] = tm;
    vals[3] = td;
    vals[4] = th;
    vals[5] = tmi;
    vals[6] = dly;
    vals[7] = extra;
    drain();
    for (int i = 0; i < 8; i++) begin
      idx = cfg_reg_t'(i);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx)
        REG_MODE_FROM_NOW:       cfg_mode = vals[i][0];
        REG_TARGET_YEAR:         tgt_year = vals[i][11:0];
        REG_TARGET_MONTH:        tgt_month = vals[i][3:0];
        REG_TARGET_DAY:          tgt_day = vals[i][4:0];
        REG_TARGET_HOUR:         tgt_hour = vals[i][4:0];
        REG_TARGET_MINUTE:       tgt_minute = vals[i][5:0];
        REG_DELAY_MINUTES:       dly_minutes = vals[i];
        REG_DELAY_EXTRA_SECONDS: dly_extra = vals[i][5:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_tick(input tick_t t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (!in_ready);
    countdown_q.push_back(predict_countdown(t));
    sent_ticks++;
  endtask

  // first tick loads the delay; count it down past zero, then rewrite it
  task automatic test_from_now_countdown();
    load_settings(16'd1, 16'd2000, 16'd0, 16'd1, 16'd0, 16'd0, 16'd6, 16'd59);
    send_tick(make_tick(2024, 2, 9, 8, 10, 0));
    send_tick(make_tick(2024, 2, 9, 8, 10, 60));
    for (int mi = 11; mi <= 16; mi++) send_tick(make_tick(2024, 2, 9, 8, mi, 0));
    send_tick(make_tick(2024, 2, 9, 8, 17, 29));
    load_settings(16'd1, 16'd2000, 16'd0, 16'd1, 16'd0, 16'd0, 16'hFFFF, 16'd63);
    send_tick(make_tick(2024, 2, 9, 8, 17, 63));
    send_tick(make_tick(2024, 2, 9, 8, 18, 0));
  endtask

  task automatic test_date_edges();
    load_settings(16'd0, 16'd2000, 16'd0, 16'd1, 16'd0, 16'd0, 16'hFFFF, 16'd59);
    send_tick(make_tick(2000, 0, 1, 0, 0, 0));
    send_tick(make_tick(1999, 11, 31, 23, 59, 0));
    send_tick(make_tick(2024, 5, 15, 12, 30, 10));
    send_tick(make_tick(0, 0, 1, 0, 0, 0));
    // target past february: year steps look at the following year
    load_settings(16'd0, 16'd2001, 16'd2, 16'd1, 16'd0, 16'd1, 16'd0, 16'd0);
    send_tick(make_tick(2000, 2, 1, 0, 0, 30));
    send_tick(make_tick(2001, 2, 1, 0, 0, 29));
    send_tick(make_tick(2001, 2, 1, 0, 0, 30));
    send_tick(make_tick(2001, 15, 31, 31, 63, 63));
    // out of range target fields and the top year
    load_settings(16'd0, 16'd4095, 16'd13, 16'd31, 16'd31, 16'd63, 16'd0, 16'd63);
    send_tick(make_tick(4095, 0, 0, 0, 0, 0));
    send_tick(make_tick(3999, 1, 29, 23, 59, 60));
    load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_tick(make_tick(4095, 15, 31, 31, 63, 63));
    send_tick(make_tick(0, 0, 0, 0, 0, 0));
  endtask

  task automatic run_date_phase(input int n, input bit far);
    int r;
    int yy;
    int mi;
    if (far)
      load_settings(16'd0, 16'($urandom_range(0, 4095)), 16'($urandom_range(0, 11)),
                    16'($urandom_range(1, 31)), 16'($urandom_range(0, 23)),
                    16'($urandom_range(0, 59)), 16'($urandom), 16'($urandom_range(0, 59)));
    else if ($urandom_range(0, 4) == 0)
      load_settings(16'($urandom) & 16'hFFFE, 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    else
      load_settings(16'd0, 16'($urandom_range(1900, 2100)), 16'($urandom_range(0, 11)),
                    16'($urandom_range(1, 31)), 16'($urandom_range(0, 23)),
                    16'($urandom_range(0, 59)), 16'($urandom), 16'($urandom_range(0, 59)));
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (far) begin
        send_tick(make_tick($urandom_range(0, 4095), $urandom_range(0, 11),
                            $urandom_range(1, 31), $urandom_range(0, 23),
                            $urandom_range(0, 59), $urandom_range(0, 60)));
      end else if (r < 40) begin
        // same minute or the one before the target: lands around the final window
        mi = tgt_minute;
        if (mi > 0 && $urandom_range(0, 1) == 1) mi--;
        send_tick(make_tick(tgt_year, tgt_month, tgt_day, tgt_hour, mi,
                            $urandom_range(0, 60)));
      end else if (r < 80) begin
        yy = int'(tgt_year) + int'($urandom_range(0, 6)) - 3;
        if (yy < 0) yy = 0;
        if (yy > 4095) yy = 4095;
        send_tick(make_tick(yy, $urandom_range(0, 11), $urandom_range(1, 31),
                            $urandom_range(0, 23), $urandom_range(0, 59),
                            $urandom_range(0, 60)));
      end else begin
        send_tick(noise_tick());
      end
    end
  endtask

  task automatic run_from_now_phase(input int n);
    int mi;
    int sec;
    int step;
    load_settings(16'($urandom) | 16'd1, 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom),
                  ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 59)));
    mi = $urandom_range(0, 59);
    sec = $urandom_range(0, 59);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        send_tick(noise_tick());
      end else begin
        // running wall clock, mostly short steps with an odd long jump
        step = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 300) : $urandom_range(1, 40);
        sec += step;
        mi = (mi + sec / 60) % 60;
        sec = sec % 60;
        send_tick(make_tick($urandom_range(0, 4095), $urandom_range(0, 11),
                            $urandom_range(1, 31), $urandom_range(0, 23), mi,
                            ($urandom_range(0, 19) == 0) ? 60 : sec));
      end
    end
  endtask

  task automatic test_random_mix();
    int r;
    int first;
    first = sent_ticks;
    while (sent_ticks - first < RANDOM_TICKS) begin
      calm = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 9);
      if (r < 6) run_date_phase($urandom_range(10, 40), 1'b0);
      else if (r < 7) run_date_phase($urandom_range(3, 8), 1'b1);
      else run_from_now_phase($urandom_range(10, 40));
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (countdown_q.size() == 0) begin
        $display("%0t: result beat with nothing expected: seconds_left=%0d final_window=%0b",
                 $time, out_data.seconds_left, out_data.final_window);
        errors++;
      end else begin
        want = countdown_q.pop_front();
        if (out_data.seconds_left !== want.seconds_left) begin
          $display("%0t: seconds_left expected %0d actual %0d",
                   $time, want.seconds_left, out_data.seconds_left);
          errors++;
        end
        if (out_data.final_window !== want.final_window) begin
          $display("%0t: final_window expected %0b actual %0b",
                   $time, want.final_window, out_data.final_window);
          errors++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_MODE_FROM_NOW;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    errors = 0;
    sent_ticks = 0;
    calm = 1'b0;
    stall_left = 0;
    cfg_mode = 1'b0;
    tgt_year = 12'd2000;
    tgt_month = 4'd0;
    tgt_day = 5'd1;
    tgt_hour = 5'd0;
    tgt_minute = 6'd0;
    dly_minutes = 16'd0;
    dly_extra = 6'd0;
    cd_started = 1'b0;
    cd_last_minute = 6'd0;
    cd_remaining = 16'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_from_now_countdown();
    test_date_edges();
    test_random_mix();

    drain();
    repeat (600) @(posedge clk);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
